/* rtl/button_short_long_press_debouncer_macros.svh */
// assertion macros shared by the debouncer rtl
`ifndef BUTTON_SHORT_LONG_PRESS_DEBOUNCER_MACROS_SVH
`define BUTTON_SHORT_LONG_PRESS_DEBOUNCER_MACROS_SVH

// clocked property, off while reset is asserted
`define BSLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// condition that must never hold
`define BSLP_ASSERT_NEVER(lbl, cond, msg) \
	`BSLP_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/bslp_pkg.sv */
// types and constants shared by the debouncer rtl
package bslp_pkg;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_CHECK = 2'd1,
		REQ_ACK   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_SHORT = 2'd1,
		KIND_LONG  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_SHORT_THR  = 3'd0,
		CFG_MID_THR    = 3'd1,
		CFG_LONG_THR   = 3'd2,
		CFG_DEAD_SHORT = 3'd3,
		CFG_DEAD_LONG  = 3'd4,
		CFG_AUTO_ACK   = 3'd5
	} cfg_idx_t;

	localparam logic [7:0] RST_SHORT_THR  = 8'd5;
	localparam logic [7:0] RST_MID_THR    = 8'd50;
	localparam logic [7:0] RST_LONG_THR   = 8'd100;
	localparam logic [7:0] RST_DEAD_SHORT = 8'd10;
	localparam logic [7:0] RST_DEAD_LONG  = 8'd50;
	localparam logic [7:0] RST_AUTO_ACK   = 8'd0;

	// number of buttons that have a pin bit and an auto-ack bit
	localparam int PIN_BITS = 8;

	typedef struct packed {
		logic [7:0] short_thr;
		logic [7:0] mid_thr;
		logic [7:0] long_thr;
		logic [7:0] dead_short;
		logic [7:0] dead_long;
	} btn_cfg_t;

	typedef struct packed {
		logic tick;
		logic pressed;
		logic clear;
	} btn_cmd_t;

	typedef struct packed {
		logic short_pend;
		logic long_pend;
	} btn_stat_t;

endpackage

/* rtl/bslp_btn.sv */
// per-button debounce and short / long press state
`include "button_short_long_press_debouncer_macros.svh"

module bslp_btn
	import bslp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  btn_cfg_t  cfg,
	input  btn_cmd_t  cmd,
	output btn_stat_t stat
);

	logic [7:0] press_cnt_q, press_cnt_d;
	logic [7:0] dead_cnt_q, dead_cnt_d;
	logic       short_pend_q, short_pend_d;
	logic       long_pend_q, long_pend_d;
	logic       cand_q, cand_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_cnt_q  <= '0;
			dead_cnt_q   <= '0;
			short_pend_q <= 1'b0;
			long_pend_q  <= 1'b0;
			cand_q       <= 1'b0;
		end else begin
			press_cnt_q  <= press_cnt_d;
			dead_cnt_q   <= dead_cnt_d;
			short_pend_q <= short_pend_d;
			long_pend_q  <= long_pend_d;
			cand_q       <= cand_d;
		end
	end

	always_comb begin
		press_cnt_d  = press_cnt_q;
		dead_cnt_d   = dead_cnt_q;
		short_pend_d = short_pend_q;
		long_pend_d  = long_pend_q;
		cand_d       = cand_q;
		// a pending press freezes the button until cleared
		if (cmd.tick && !short_pend_q && !long_pend_q) begin
			if (dead_cnt_q != 8'd0) begin
				dead_cnt_d = dead_cnt_q - 8'd1;
			end else if (press_cnt_q == 8'd0) begin
				if (cmd.pressed) begin
					press_cnt_d = 8'd1;
				end
			end else if (press_cnt_q == cfg.short_thr) begin
				if (cmd.pressed) begin
					cand_d = 1'b1;
				end
				press_cnt_d = press_cnt_q + 8'd1;
			end else if (press_cnt_q == cfg.mid_thr) begin
				if (cand_q && !cmd.pressed) begin
					short_pend_d = 1'b1;
					dead_cnt_d   = cfg.dead_short;
					cand_d       = 1'b0;
					press_cnt_d  = 8'd0;
				end else begin
					press_cnt_d = press_cnt_q + 8'd1;
				end
			end else if (press_cnt_q == cfg.long_thr) begin
				if (cmd.pressed) begin
					long_pend_d = 1'b1;
					dead_cnt_d  = cfg.dead_long;
				end else if (cand_q) begin
					short_pend_d = 1'b1;
					dead_cnt_d   = cfg.dead_short;
				end
				press_cnt_d = 8'd0;
				cand_d      = 1'b0;
			end else begin
				press_cnt_d = press_cnt_q + 8'd1;
			end
		end
		if (cmd.clear) begin
			short_pend_d = 1'b0;
			long_pend_d  = 1'b0;
		end
	end

	assign stat.short_pend = short_pend_q;
	assign stat.long_pend  = long_pend_q;

	`BSLP_ASSERT_NEVER(a_pend_excl, short_pend_q && long_pend_q, "both presses pending")
	`BSLP_ASSERT(a_long_dead, $rose(long_pend_q) |-> dead_cnt_q == $past(cfg.dead_long), "long dead time not loaded")
	`BSLP_ASSERT(a_short_dead, $rose(short_pend_q) |-> dead_cnt_q == $past(cfg.dead_short), "short dead time not loaded")

endmodule

/* rtl/button_short_long_press_debouncer.sv */
// top level: request register, button array, config registers, result register
//
//  channel | signals                                        | role
//  --------+------------------------------------------------+------------------------------
//  in      | in_valid in_ready req_type button_index pin_levels | tick, check or ack request
//  out     | out_valid out_ready press_kind checked_button  | one result per check
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data         | register writes, always ready
//
// one request per cycle unless a check is held by a full result register: a request is registered
// on transfer and executed from the request register, all buttons updating in parallel; a check
// result passes through the request register and is then registered in the result register.
// reset clears all button state and loads the config defaults.
// a stalled result holds only a check in the request register; ticks and acks pass, but no request enters behind it.
`include "button_short_long_press_debouncer_macros.svh"

module button_short_long_press_debouncer
	import bslp_pkg::*;
#(
	parameter int NUM_BUTTONS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [2:0] button_index,
	input  logic [7:0] pin_levels,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] press_kind,
	output logic [2:0] checked_button,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	btn_cfg_t   cfg_q;
	logic [7:0] auto_ack_q;

	logic       valid_s1;
	req_t       req_s1;
	logic [2:0] idx_s1;
	logic [7:0] pins_s1;
	logic       s1_adv;

	logic       out_valid_q;
	kind_t      kind_q;
	logic [2:0] checked_q;

	logic [NUM_BUTTONS-1:0] sel;
	logic [NUM_BUTTONS-1:0] short_vec;
	logic [NUM_BUTTONS-1:0] long_vec;
	kind_t                  kind;
	logic                   do_tick;
	logic                   do_check;
	logic                   do_ack;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_thr  <= RST_SHORT_THR;
			cfg_q.mid_thr    <= RST_MID_THR;
			cfg_q.long_thr   <= RST_LONG_THR;
			cfg_q.dead_short <= RST_DEAD_SHORT;
			cfg_q.dead_long  <= RST_DEAD_LONG;
			auto_ack_q       <= RST_AUTO_ACK;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SHORT_THR:  cfg_q.short_thr  <= cfg_data;
				CFG_MID_THR:    cfg_q.mid_thr    <= cfg_data;
				CFG_LONG_THR:   cfg_q.long_thr   <= cfg_data;
				CFG_DEAD_SHORT: cfg_q.dead_short <= cfg_data;
				CFG_DEAD_LONG:  cfg_q.dead_long  <= cfg_data;
				CFG_AUTO_ACK:   auto_ack_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// request register; a check waits here while the result register is full and not being taken
	assign s1_adv   = valid_s1 && (req_s1 != REQ_CHECK || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1  <= req_t'(req_type);
			idx_s1  <= button_index;
			pins_s1 <= pin_levels;
		end
	end

	assign do_tick  = s1_adv && req_s1 == REQ_TICK;
	assign do_check = s1_adv && req_s1 == REQ_CHECK;
	assign do_ack   = s1_adv && req_s1 == REQ_ACK;

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
		btn_cmd_t  cmd;
		btn_stat_t stat;
		logic      pressed;
		logic      auto_ack;

		// buttons without a pin bit read released and never auto-acknowledge
		if (b < PIN_BITS) begin : g_pin
			assign sel[b]   = idx_s1 == 3'(b);
			assign pressed  = ~pins_s1[b];
			assign auto_ack = auto_ack_q[b];
		end else begin : g_nopin
			assign sel[b]   = 1'b0;
			assign pressed  = 1'b0;
			assign auto_ack = 1'b0;
		end

		assign cmd.tick    = do_tick;
		assign cmd.pressed = pressed;
		assign cmd.clear   = sel[b] && (do_ack || (do_check && auto_ack));

		bslp_btn u_btn (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg_q),
			.cmd    (cmd),
			.stat   (stat)
		);

		assign short_vec[b] = sel[b] && stat.short_pend;
		assign long_vec[b]  = sel[b] && stat.long_pend;
	end

	// long wins over short
	always_comb begin
		if (|long_vec) begin
			kind = KIND_LONG;
		end else if (|short_vec) begin
			kind = KIND_SHORT;
		end else begin
			kind = KIND_NONE;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_check) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_check) begin
			kind_q    <= kind;
			checked_q <= idx_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign press_kind     = kind_q;
	assign checked_button = checked_q;

	`BSLP_ASSERT(a_out_src, $rose(out_valid_q) |-> $past(valid_s1 && req_s1 == REQ_CHECK), "result without a check")
	`BSLP_ASSERT(a_stall_why, valid_s1 && !s1_adv |-> req_s1 == REQ_CHECK && out_valid_q && !out_ready, "request stalled without cause")
	`BSLP_ASSERT(a_check_res, do_check |=> out_valid_q && checked_q == $past(idx_s1), "check result lost")

endmodule
